### hdl/cpb_pkg.sv
// cpb_pkg: shared types, codes and constants of the column predicate bitmap core
// no dependencies
package cpb_pkg;

    localparam int unsigned WORD_BITS_DEF = 64;
    localparam int unsigned MAX_WORDS_DEF = 65536;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0]
    {
        DT_INT32 = 2'd0,
        DT_INT64 = 2'd1,
        DT_FP32  = 2'd2,
        DT_FP64  = 2'd3
    } data_type_t;

    typedef enum logic [2:0]
    {
        OP_EQ = 3'd0,
        OP_NE = 3'd1,
        OP_GT = 3'd2,
        OP_LT = 3'd3,
        OP_GE = 3'd4,
        OP_LE = 3'd5
    } cmp_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONST      = 2'd3;

    typedef struct packed
    {
        logic [63:0] left_value;
        logic [63:0] right_value;
        logic        last_row;
    } in_beat_t;

    typedef struct packed
    {
        logic [63:0] mask_word;
        logic [15:0] word_index;
        logic [6:0]  rows_in_word;
        logic        last_word;
    } out_beat_t;

    // classified row handed from front to back
    typedef struct packed
    {
        logic hit;
        logic last;
    } cls_t;

endpackage

### hdl/column_predicate_bitmap_core.sv
// column_predicate_bitmap_core: top level of the column predicate bitmap block
// depends on cpb_pkg, cpb_front, cpb_queue, cpb_back
//
// usage
// - in channel: one column row per beat (left_value, right_value, last_row),
//   accepted when in_valid is high and in_stall low
// - out channel: one 64-row selection word per beat, taken when out_valid is
//   high and out_stall low; bit k of mask_word is row k of the word
// - config port: cfg_we, cfg_index, cfg_data; write only while idle
// - throughput: one row per cycle while out_stall is low, set by the compare
//   in the front stage and the one-bit insert in the back stage
// - the closing row of a word is registered in the front stage, written to
//   the queue, then taken into the output register, which raises out_valid
// - reset clears accumulator, row position, word counter and all valid flags;
//   registers return to int32, EQ, constant mode, constant zero
// - a stalled receiver holds the output word, the back part then stops,
//   the two-entry queue fills and in_stall rises; nothing is lost
module column_predicate_bitmap_core
    import cpb_pkg::*;
#(
    parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_beat_t    in_beat,
    output logic        out_valid,
    input  logic        out_stall,
    output out_beat_t   out_beat
);

    logic [1:0]  dtype_reg;
    logic [2:0]  op_reg;
    logic        rsel_reg;
    logic [63:0] const_reg;

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dtype_reg <= DT_INT32;
            op_reg    <= OP_EQ;
            rsel_reg  <= 1'b1;
            const_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DATA_TYPE:  dtype_reg <= cfg_data[1:0];
                REG_COMPARE_OP: op_reg    <= cfg_data[2:0];
                REG_RIGHT_SEL:  rsel_reg  <= cfg_data[0];
                REG_CONST:      const_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_stall, q_valid, q_stall;
    cls_t f_cls, q_cls;

    cpb_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_type        (dtype_reg),
        .compare_op       (op_reg),
        .right_from_const (rsel_reg),
        .const_value      (const_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_beat          (in_beat),
        .cls_valid        (f_valid),
        .cls_stall        (f_stall),
        .cls              (f_cls)
    );

    cpb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (f_cls),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_data  (q_cls)
    );

    cpb_back #(.MAX_WORDS(MAX_WORDS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_stall (q_stall),
        .cls       (q_cls),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

endmodule

### hdl/cpb_front.sv
// cpb_front: registers the row, compares it under the configured type and operator
// depends on cpb_pkg
module cpb_front
    import cpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] data_type,
    input  logic [2:0] compare_op,
    input  logic       right_from_const,
    input  logic [63:0] const_value,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_beat_t   in_beat,
    output logic       cls_valid,
    input  logic       cls_stall,
    output cls_t       cls
);

    logic        s_valid_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic        last_reg;

    logic [63:0] a32, b32;
    logic        lt_i, eq_i, nan, both_zero;
    logic        ord_lt, ord_eq, ord_gt, hit;
    logic        load;

    assign in_stall = s_valid_reg && cls_stall;
    assign load     = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (load)
            s_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            a_reg    <= in_beat.left_value;
            b_reg    <= right_from_const ? const_value : in_beat.right_value;
            last_reg <= in_beat.last_row;
        end
    end

    // unsigned ordering key for sign-magnitude floats, built from raw bits
    function automatic logic [63:0] fkey(input logic [63:0] v, input logic s);
        return s ? ~v : (v | 64'h8000_0000_0000_0000);
    endfunction

    always_comb
    begin
        logic [63:0] ka, kb;
        ka = '0;
        kb = '0;
        nan = 1'b0;
        both_zero = 1'b0;
        a32 = {32'd0, a_reg[31:0]};
        b32 = {32'd0, b_reg[31:0]};
        unique case (data_type_t'(data_type))
            DT_INT32:
            begin
                ka = {~a_reg[31], {32{a_reg[31]}}, a_reg[30:0]};
                kb = {~b_reg[31], {32{b_reg[31]}}, b_reg[30:0]};
            end
            DT_INT64:
            begin
                ka = {~a_reg[63], a_reg[62:0]};
                kb = {~b_reg[63], b_reg[62:0]};
            end
            DT_FP32:
            begin
                nan = (&a32[30:23] && |a32[22:0]) || (&b32[30:23] && |b32[22:0]);
                both_zero = (a32[30:0] == 31'd0) && (b32[30:0] == 31'd0);
                ka = fkey({a32[31], 32'd0, a32[30:0]}, a32[31]);
                kb = fkey({b32[31], 32'd0, b32[30:0]}, b32[31]);
            end
            DT_FP64:
            begin
                nan = (&a_reg[62:52] && |a_reg[51:0]) || (&b_reg[62:52] && |b_reg[51:0]);
                both_zero = (a_reg[62:0] == 63'd0) && (b_reg[62:0] == 63'd0);
                ka = fkey({a_reg[63], a_reg[62:0]}, a_reg[63]);
                kb = fkey({b_reg[63], b_reg[62:0]}, b_reg[63]);
            end
            default: ;
        endcase
        lt_i = ka < kb;
        eq_i = ka == kb;
        ord_eq = !nan && (both_zero || eq_i);
        ord_lt = !nan && !ord_eq && lt_i;
        ord_gt = !nan && !ord_eq && !lt_i;
        unique case (compare_op)
            OP_EQ:   hit = ord_eq;
            OP_NE:   hit = !ord_eq;
            OP_GT:   hit = ord_gt;
            OP_LT:   hit = ord_lt;
            OP_GE:   hit = ord_gt || ord_eq;
            OP_LE:   hit = ord_lt || ord_eq;
            default: hit = 1'b0;
        endcase
    end

    assign cls_valid = s_valid_reg;
    assign cls.hit   = hit;
    assign cls.last  = last_reg;

endmodule

### hdl/cpb_queue.sv
// cpb_queue: two-entry queue of classified rows between front and back
// depends on cpb_pkg
module cpb_queue
    import cpb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  cls_t wr_data,
    output logic rd_valid,
    input  logic rd_stall,
    output cls_t rd_data
);

    cls_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

### hdl/cpb_back.sv
// cpb_back: packs result bits into 64-row words and holds the output register
// depends on cpb_pkg
module cpb_back
    import cpb_pkg::*;
#(
    parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cls_valid,
    output logic      cls_stall,
    input  cls_t      cls,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    localparam logic [16:0] WRAP = (MAX_WORDS >= 65536) ? 17'd65536 : 17'(MAX_WORDS);

    logic [63:0] acc_reg, acc_next;
    logic [5:0]  pos_reg;
    logic [15:0] wcnt_reg;
    logic        ovalid_reg;
    out_beat_t   obeat_reg;
    logic        take, emit;
    logic [16:0] wnext;

    assign cls_stall = ovalid_reg && out_stall;
    assign take      = cls_valid && !cls_stall;
    assign emit      = take && (cls.last || pos_reg == 6'd63);
    assign acc_next  = acc_reg | ({63'd0, cls.hit} << pos_reg);
    assign wnext     = {1'b0, wcnt_reg} + 17'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pos_reg    <= '0;
            wcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (!cls_stall)
                ovalid_reg <= emit;
            if (take)
            begin
                if (emit)
                begin
                    acc_reg <= '0;
                    pos_reg <= '0;
                    if (cls.last)
                        wcnt_reg <= '0;
                    else
                        wcnt_reg <= (wnext >= WRAP) ? 16'd0 : wnext[15:0];
                end
                else
                begin
                    acc_reg <= acc_next;
                    pos_reg <= pos_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            obeat_reg.mask_word    <= acc_next;
            obeat_reg.word_index   <= wcnt_reg;
            obeat_reg.rows_in_word <= {1'b0, pos_reg} + 7'd1;
            obeat_reg.last_word    <= cls.last;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_beat  = obeat_reg;

endmodule
